// File: design/ifmt_pkg.sv
// ----------------------------------------------------------------------------
// Integer field formatter package
// Shared word types, character codes and sizing constants.
// ----------------------------------------------------------------------------
package ifmt_pkg;

  localparam int MAX_WIDTH_DEF = 40;
  localparam int POS_W         = 7;
  localparam int NUM_DIGITS    = 10;
  localparam int VALUE_W       = 32;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_BLANK = 8'h20;

  typedef struct packed {
    logic signed [31:0] value;
    logic [5:0]         width;
    logic [5:0]         min_digits;
  } in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [NUM_DIGITS-1:0][3:0] digits;
    logic [3:0]                 ndig;
    logic                       neg;
    logic                       star;
    logic [POS_W-1:0]           start;
    logic [POS_W-1:0]           width;
  } job_t;

endpackage

// File: design/ifmt_front.sv
// ----------------------------------------------------------------------------
// Integer field formatter front end
// Accepts a word, converts the magnitude to decimal and classifies the field.
// ----------------------------------------------------------------------------
module ifmt_front #(
  parameter int MAX_WIDTH = ifmt_pkg::MAX_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  ifmt_pkg::in_t   item,
  output logic            busy,
  input  logic            q_full,
  output logic            q_push,
  output ifmt_pkg::job_t  q_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CONV = 3'b010,
    S_PUSH = 3'b100
  } state_t;

  state_t                                state;
  logic [ifmt_pkg::VALUE_W-1:0]          mag;
  logic [ifmt_pkg::NUM_DIGITS-1:0][3:0]  bcd;
  logic [ifmt_pkg::NUM_DIGITS-1:0][3:0]  bcd_adj;
  logic [4:0]                            cnt;
  logic                                  neg;
  logic [ifmt_pkg::POS_W-1:0]            wsat;
  logic [ifmt_pkg::POS_W-1:0]            wreg;
  logic [5:0]                            mind;
  logic [3:0]                            ndig;
  logic [ifmt_pkg::POS_W-1:0]            body;
  logic [ifmt_pkg::POS_W-1:0]            total;

  assign busy = (state != S_IDLE);

  assign wsat = (ifmt_pkg::POS_W'(item.width) > ifmt_pkg::POS_W'(MAX_WIDTH))
              ? ifmt_pkg::POS_W'(MAX_WIDTH) : ifmt_pkg::POS_W'(item.width);

  always_comb begin
    for (int k = 0; k < ifmt_pkg::NUM_DIGITS; k++) begin
      bcd_adj[k] = (bcd[k] >= 4'd5) ? bcd[k] + 4'd3 : bcd[k];
    end
  end

  always_comb begin
    ndig = 4'd1;
    for (int k = 1; k < ifmt_pkg::NUM_DIGITS; k++) begin
      if (bcd[k] != 4'd0) begin
        ndig = 4'(k + 1);
      end
    end
  end

  assign body  = (ifmt_pkg::POS_W'(ndig) > ifmt_pkg::POS_W'(mind))
               ? ifmt_pkg::POS_W'(ndig) : ifmt_pkg::POS_W'(mind);
  assign total = body + ifmt_pkg::POS_W'(neg);

  always_comb begin
    q_data        = '0;
    q_data.digits = bcd;
    q_data.ndig   = ndig;
    q_data.neg    = neg;
    q_data.star   = (total > wreg);
    q_data.start  = wreg - total;
    q_data.width  = wreg;
  end

  assign q_push = (state == S_PUSH) && (wreg != '0) && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_CONV;
          end
        end
        S_CONV: begin
          if (cnt == 5'd31) begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if ((wreg == '0) || !q_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && start) begin
      neg  <= item.value[ifmt_pkg::VALUE_W-1];
      mag  <= item.value[ifmt_pkg::VALUE_W-1] ? (32'd0 - item.value) : item.value;
      bcd  <= '0;
      cnt  <= '0;
      wreg <= wsat;
      mind <= item.min_digits;
    end else if (state == S_CONV) begin
      {bcd, mag} <= {bcd_adj, mag} << 1;
      cnt        <= cnt + 5'd1;
    end
  end

endmodule

// File: design/ifmt_queue.sv
// ----------------------------------------------------------------------------
// Integer field formatter job queue
// Short first-in first-out buffer between the front end and the emitter.
// ----------------------------------------------------------------------------
module ifmt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ifmt_pkg::job_t  wdata,
  input  logic            pop,
  output ifmt_pkg::job_t  rdata,
  output logic            full,
  output logic            empty
);

  localparam int AW = $clog2(ifmt_pkg::QUEUE_DEPTH);

  ifmt_pkg::job_t  mem [ifmt_pkg::QUEUE_DEPTH];
  logic [AW-1:0]   wptr;
  logic [AW-1:0]   rptr;
  logic [AW:0]     count;

  assign full  = (count == (AW + 1)'(ifmt_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(ifmt_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(ifmt_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (AW + 1)'(push) - (AW + 1)'(pop);
    end
  end

endmodule

// File: design/ifmt_back.sv
// ----------------------------------------------------------------------------
// Integer field formatter back end
// Emits the characters of one field per job, one character each cycle.
// ----------------------------------------------------------------------------
module ifmt_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  ifmt_pkg::job_t  q_data,
  output logic            q_pop,
  output logic            strobe,
  output ifmt_pkg::out_t  result
);

  ifmt_pkg::job_t              job;
  logic                        active;
  logic [ifmt_pkg::POS_W-1:0]  pos;
  logic [ifmt_pkg::POS_W-1:0]  dig_idx;
  logic                        last_now;
  logic [7:0]                  ch;

  assign last_now = active && (pos == job.width - 1'b1);
  assign q_pop    = (!active || last_now) && !q_empty;
  assign dig_idx  = job.width - 1'b1 - pos;

  always_comb begin
    if (job.star) begin
      ch = ifmt_pkg::CH_STAR;
    end else if (pos < job.start) begin
      ch = ifmt_pkg::CH_BLANK;
    end else if (job.neg && (pos == job.start)) begin
      ch = ifmt_pkg::CH_MINUS;
    end else if (dig_idx < ifmt_pkg::POS_W'(job.ndig)) begin
      ch = ifmt_pkg::CH_ZERO + 8'(job.digits[dig_idx[3:0]]);
    end else begin
      ch = ifmt_pkg::CH_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      result.char_out <= ch;
      result.last     <= last_now;
    end
    if (q_pop) begin
      job <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
      pos    <= '0;
    end else begin
      strobe <= active;
      if (q_pop) begin
        active <= 1'b1;
        pos    <= '0;
      end else if (last_now) begin
        active <= 1'b0;
      end else if (active) begin
        pos <= pos + 1'b1;
      end
    end
  end

endmodule

// File: design/integer_field_formatter.sv
// ----------------------------------------------------------------------------
// Integer field formatter
// Formats a signed integer into a right-aligned decimal field of fixed width.
// ----------------------------------------------------------------------------
// The front end takes one word at a time: an accept state, the binary to decimal
// shift-and-adjust loop, and a hand-off state. It can convert the next word while the
// back end emits earlier fields. A field passes through the queue, the job register
// and the output register, then its characters follow one per cycle with no gaps;
// a zero width emits nothing. Synchronous reset empties the queue and idles both
// ends; the receiver cannot stall.
module integer_field_formatter #(
  parameter int MAX_WIDTH = ifmt_pkg::MAX_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  ifmt_pkg::in_t   item,
  output logic            busy,
  output logic            strobe,
  output ifmt_pkg::out_t  result
);

  ifmt_pkg::job_t  push_data;
  ifmt_pkg::job_t  pop_data;
  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_empty;

  ifmt_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (push_data)
  );

  ifmt_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (push_data),
    .pop   (q_pop),
    .rdata (pop_data),
    .full  (q_full),
    .empty (q_empty)
  );

  ifmt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (pop_data),
    .q_pop   (q_pop),
    .strobe  (strobe),
    .result  (result)
  );

endmodule

// File: design/ifmt_checker.sv
// ----------------------------------------------------------------------------
// Integer field formatter checker
// Port-level properties of the formatter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ifmt_checker (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic            strobe,
  input ifmt_pkg::out_t  result
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("Formatter did not go busy after accepting a word.");

  a_field_contiguous: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last) |=> strobe)
    else $error("Field characters were not emitted back to back.");

  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    strobe |-> ((result.char_out == ifmt_pkg::CH_BLANK) ||
                (result.char_out == ifmt_pkg::CH_STAR) ||
                (result.char_out == ifmt_pkg::CH_MINUS) ||
                ((result.char_out >= ifmt_pkg::CH_ZERO) &&
                 (result.char_out <= 8'h39))))
    else $error("Emitted character is outside the field alphabet.");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!strobe && !busy))
    else $error("Formatter not idle after reset.");

endmodule

bind integer_field_formatter ifmt_checker u_ifmt_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .result (result)
);

// File: bench/tb_integer_field_formatter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Integer field formatter testbench
// Sends signed values with field widths and minimum digit counts to the block,
// predicts every character of each right-aligned field, and compares each
// output word with the oldest predicted character. Directed tests cover the
// value extremes, zero width, width saturation, asterisk overflow and zero
// padding; a random phase follows with bursty input and one full drain.
// ----------------------------------------------------------------------------
module tb_integer_field_formatter;

  localparam int MAX_WIDTH   = ifmt_pkg::MAX_WIDTH_DEF;
  localparam int LATENCY     = 100;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_WORDS = 150;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           start = 1'b0;
  ifmt_pkg::in_t  item = '0;
  logic           busy;
  logic           strobe;
  ifmt_pkg::out_t result;

  ifmt_pkg::out_t pending_chars[$];
  int   error_count = 0;
  int   words_sent = 0;
  int   chars_checked = 0;
  int   star_fields = 0;
  int   neg_fields = 0;
  int   burst_left = 0;
  int   cycle_count = 0;

  integer_field_formatter dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void predict_field(ifmt_pkg::in_t w);
    logic [31:0]    mag;
    logic           neg;
    logic [7:0]     digs[10];
    logic [7:0]     fld[MAX_WIDTH];
    int unsigned    fw;
    int unsigned    nd;
    int unsigned    body;
    int unsigned    total;
    int unsigned    lead;
    ifmt_pkg::out_t ch;
    fw = (w.width > MAX_WIDTH) ? MAX_WIDTH : w.width;
    if (fw == 0) return;
    neg = w.value[31];
    mag = neg ? (32'd0 - w.value) : w.value;
    nd = 0;
    do begin
      digs[nd] = ifmt_pkg::CH_ZERO + 8'(mag % 10);
      mag = mag / 10;
      nd++;
    end while (mag != 0 && nd < 10);
    body = (nd < w.min_digits) ? w.min_digits : nd;
    total = body + (neg ? 1 : 0);
    if (total > fw) begin
      star_fields++;
      for (int i = 0; i < fw; i++) fld[i] = ifmt_pkg::CH_STAR;
    end else begin
      lead = fw - total;
      for (int i = 0; i < lead; i++) fld[i] = ifmt_pkg::CH_BLANK;
      if (neg) begin
        fld[lead] = ifmt_pkg::CH_MINUS;
        neg_fields++;
      end
      for (int i = 0; i < body; i++) begin
        fld[fw - 1 - i] = (i < nd) ? digs[i] : ifmt_pkg::CH_ZERO;
      end
    end
    for (int i = 0; i < fw; i++) begin
      ch.char_out = fld[i];
      ch.last = (i + 1 == fw);
      pending_chars.push_back(ch);
    end
  endfunction

  task automatic send_word(input logic signed [31:0] value, input int fw, input int md);
    ifmt_pkg::in_t w;
    w.value = value;
    w.width = 6'(fw);
    w.min_digits = 6'(md);
    item <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predict_field(w);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 6);
      start <= 1'b0;
      repeat ($urandom_range(1, 45)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic test_extremes();
    send_word(32'sd0, 1, 0);
    send_word(32'sd0, 5, 0);
    send_word(32'sd2147483647, 12, 0);
    send_word(-32'sd2147483648, 11, 0);
    send_word(-32'sd2147483648, 40, 0);
    send_word(-32'sd1, 2, 0);
    send_word(32'sd1234567, 8, 0);
    send_word(-32'sd7654321, 8, 3);
  endtask

  task automatic test_zero_width();
    send_word(32'sd42, 0, 0);
    send_word(-32'sd2147483648, 0, 63);
  endtask

  task automatic test_saturation();
    send_word(32'sd987654321, 41, 0);
    send_word(-32'sd12345, 63, 40);
  endtask

  task automatic test_overflow();
    send_word(32'sd2147483647, 9, 0);
    send_word(-32'sd5, 1, 0);
    send_word(32'sd7, 4, 5);
    send_word(32'sd3, 40, 63);
    send_word(-32'sd1, 40, 40);
  endtask

  task automatic test_min_digits();
    send_word(32'sd0, 6, 4);
    send_word(-32'sd42, 8, 6);
    send_word(32'sd123, 40, 39);
    send_word(-32'sd9, 40, 39);
    send_word(32'sd99999, 5, 5);
  endtask

  task automatic test_random();
    longint lo;
    longint mag;
    logic signed [31:0] v;
    int fw;
    int md;
    int k;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      case ($urandom_range(0, 4))
        0: v = $urandom;
        1: v = $urandom_range(0, 99) * ($urandom_range(0, 1) ? -1 : 1);
        2: begin
          v = 0;
          case ($urandom_range(0, 3))
            0: v = 32'sd2147483647;
            1: v = -32'sd2147483648;
            2: v = -32'sd1;
            default: v = 32'sd0;
          endcase
        end
        default: begin
          k = $urandom_range(1, 10);
          lo = 1;
          for (int i = 1; i < k; i++) lo = lo * 10;
          mag = lo + ((longint'($urandom) << 8 | $urandom_range(0, 255)) % (9 * lo));
          if (mag > 64'd2147483648) mag = 64'd2147483648;
          if (mag == 64'd2147483648 || $urandom_range(0, 1)) v = 32'(-mag);
          else v = 32'(mag);
        end
      endcase
      k = $urandom_range(0, 9);
      if (k == 0) fw = $urandom_range(0, 1) ? 0 : $urandom_range(41, 63);
      else if (k < 3) fw = $urandom_range(33, 40);
      else fw = $urandom_range(1, 16);
      md = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 12);
      send_word(v, fw, md);
      if (n == RANDOM_WORDS / 2) drain();
    end
  endtask

  always @(posedge clk) begin
    ifmt_pkg::out_t exp_ch;
    if (!rst && strobe) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected word char_out=%h last=%b", $time,
                 result.char_out, result.last);
        error_count++;
      end else begin
        exp_ch = pending_chars.pop_front();
        chars_checked++;
        if (result.char_out !== exp_ch.char_out) begin
          $display("%0t: char_out expected %h actual %h", $time,
                   exp_ch.char_out, result.char_out);
          error_count++;
        end
        if (result.last !== exp_ch.last) begin
          $display("%0t: last expected %b actual %b", $time, exp_ch.last, result.last);
          error_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[integer_field_formatter] ERROR");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_zero_width();
    test_saturation();
    test_overflow();
    test_min_digits();
    test_random();
    drain();
    $display("Formatted %0d words into %0d checked characters.", words_sent, chars_checked);
    $display("Fields with asterisks: %0d, with a minus sign: %0d.", star_fields, neg_fields);
    if (error_count == 0) begin
      $display("[integer_field_formatter] OK");
    end else begin
      $display("[integer_field_formatter] ERROR");
    end
    $finish;
  end

endmodule
